// File: rtl/pwsc_pkg.sv
// ----------------------------------------------------------------------------
// pwsc_pkg
// Shared types and constants of the window scorer: controller states, the
// control group that drives the cell chain, score limits and register codes.
// ----------------------------------------------------------------------------
package pwsc_pkg;

  localparam int WEIGHT_W   = 16;
  localparam int SCORE_W    = 20;
  localparam int POS_OUT_W  = 16;
  localparam int TIE_MARGIN = 2;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 20'sh80000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 20'sh7FFFF;

  // item kind carried on tuser
  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_BASE   = 1'b1;

  // configuration register indexes
  localparam logic REG_MOTIF_WIDTH   = 1'b0;
  localparam logic REG_HIT_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_SCORE,
    ST_BEST_F,
    ST_BEST_R,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                shift_base;
    logic                shift_tv;
    logic                clr_acc;
    logic                run_acc;
    logic [1:0]          wr_row;
    logic [WEIGHT_W-1:0] wr_data;
    logic                clr_scan;
  } cell_ctrl_t;

endpackage

// File: rtl/pwsc_cell.sv
// ----------------------------------------------------------------------------
// pwsc_cell
// One matrix column: its four weights, one slot of the base window, one slot
// of the reversed window, a travelling base slot and two running sums.
// ----------------------------------------------------------------------------
module pwsc_cell #(
  parameter int SUM_W = 22
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pwsc_pkg::cell_ctrl_t     ctrl,
  input  logic                     wr_sel,
  input  logic [1:0]               win_in,
  input  logic [1:0]               rev_in,
  input  logic [1:0]               tv_in,
  input  logic signed [SUM_W-1:0]  accf_in,
  input  logic signed [SUM_W-1:0]  accr_in,
  output logic [1:0]               win_out,
  output logic [1:0]               rev_out,
  output logic [1:0]               tv_out,
  output logic signed [SUM_W-1:0]  accf_out,
  output logic signed [SUM_W-1:0]  accr_out
);

  logic signed [pwsc_pkg::WEIGHT_W-1:0] wt_r [4];
  logic [1:0]              win_r, win_nxt;
  logic [1:0]              rev_r, rev_nxt;
  logic [1:0]              tv_r, tv_nxt;
  logic signed [SUM_W-1:0] accf_r, accf_nxt;
  logic signed [SUM_W-1:0] accr_r, accr_nxt;
  logic signed [pwsc_pkg::WEIGHT_W-1:0] fterm, rterm;

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      wt_r[ctrl.wr_row] <= $signed(ctrl.wr_data);
    end
  end

  // forward pairs this column with the travelling base, reverse with the
  // complement of the window slot
  assign fterm = wt_r[tv_r];
  assign rterm = wt_r[~win_r];

  always_comb begin
    win_nxt = win_r;
    rev_nxt = rev_r;
    if (ctrl.clr_scan) begin
      win_nxt = 2'b00;
      rev_nxt = 2'b00;
    end else if (ctrl.shift_base) begin
      win_nxt = win_in;
      rev_nxt = rev_in;
    end
  end

  always_comb begin
    tv_nxt = tv_r;
    if (ctrl.shift_base) begin
      tv_nxt = rev_in;
    end else if (ctrl.shift_tv) begin
      tv_nxt = tv_in;
    end
  end

  always_comb begin
    accf_nxt = accf_r;
    accr_nxt = accr_r;
    if (ctrl.clr_acc) begin
      accf_nxt = '0;
      accr_nxt = '0;
    end else if (ctrl.run_acc) begin
      accf_nxt = accf_in + SUM_W'(fterm);
      accr_nxt = accr_in + SUM_W'(rterm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 2'b00;
      rev_r <= 2'b00;
    end else begin
      win_r <= win_nxt;
      rev_r <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tv_r   <= tv_nxt;
    accf_r <= accf_nxt;
    accr_r <= accr_nxt;
  end

  assign win_out  = win_r;
  assign rev_out  = rev_r;
  assign tv_out   = tv_r;
  assign accf_out = accf_r;
  assign accr_out = accr_r;

endmodule

// File: rtl/pwm_window_scorer.sv
// ----------------------------------------------------------------------------
// pwm_window_scorer
// Log-domain position weight matrix scan over a chain of column cells.
// Weight write or base without a full window: the controller goes from IDLE
// straight to EMIT, which loads the result into the output register.
// Scored base: SHIFT lines up the reversed window (skipped at full width), SUM
// sweeps the sums through the cells, then SCORE, BEST_F, BEST_R and EMIT.
// The input is taken again once the result is in the output register.
// rst_n (synchronous) clears window, positions, best and sets motif_width 1.
// ----------------------------------------------------------------------------
module pwm_window_scorer #(
  parameter int MAX_WIDTH = 32,
  parameter int POS_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // base[1:0], column[6:2], weight[22:7], zero
  input  logic         in_tuser,   // func
  input  logic         in_tlast,   // last_base
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // window_start[15:0], fwd_score[35:16],
                                   // rev_score[55:36], forward_hit[56],
                                   // reverse_hit[57], peak_score[77:58],
                                   // best_start[93:78], best_reverse[94], zero
  output logic         out_tuser,  // window_valid
  output logic         out_tlast,  // sequence_done
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_data
);

  localparam int UW_W  = $clog2(MAX_WIDTH + 1);
  localparam int SUM_A = pwsc_pkg::WEIGHT_W + $clog2(MAX_WIDTH) + 1;
  localparam int SUM_W = (SUM_A > pwsc_pkg::SCORE_W + 1) ? SUM_A : pwsc_pkg::SCORE_W + 1;
  localparam int SW    = pwsc_pkg::SCORE_W;
  localparam int PW    = pwsc_pkg::POS_OUT_W;
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(pwsc_pkg::SCORE_MIN);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(pwsc_pkg::SCORE_MAX);

  logic [1:0]  in_base;
  logic [4:0]  in_column;
  logic [15:0] in_weight;

  assign in_base   = in_tdata[1:0];
  assign in_column = in_tdata[6:2];
  assign in_weight = in_tdata[22:7];

  pwsc_pkg::state_t     state_r, state_nxt;
  pwsc_pkg::cell_ctrl_t ctrl;
  logic                 wr_en;

  logic [UW_W-1:0]          cnt_r, cnt_nxt;
  logic [5:0]               motif_width_r;
  logic signed [SW-1:0]     hit_thr_r;
  logic [UW_W-1:0]          fill_r, fill_nxt;
  logic [POS_BITS-1:0]      count_r, count_nxt;
  logic [POS_BITS-1:0]      wstart_r, wstart_nxt;
  logic                     last_r, last_nxt;
  logic                     is_base_r, is_base_nxt;
  logic                     wvalid_r, wvalid_nxt;
  logic signed [SW-1:0]     fs_r, fs_nxt;
  logic signed [SW-1:0]     rs_r, rs_nxt;
  logic signed [SW-1:0]     best_val_r, best_val_nxt;
  logic [POS_BITS-1:0]      best_pos_r, best_pos_nxt;
  logic                     best_rev_r, best_rev_nxt;
  logic                     best_found_r, best_found_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_wvalid_r;
  logic [PW-1:0]            out_wstart_r;
  logic signed [SW-1:0]     out_fs_r, out_rs_r, out_best_r;
  logic                     out_fh_r, out_rh_r, out_brev_r, out_done_r;
  logic [PW-1:0]            out_bstart_r;

  logic [UW_W-1:0]          used_w, shift_len, fill_inc;
  logic                     emit_load, seq_clear;
  logic                     in_xfer;
  logic signed [SW:0]       best_bar, fs_ext, rs_ext;
  logic [POS_BITS+PW-1:0]   wstart_ext, bstart_ext;

  logic [1:0]              win_o  [MAX_WIDTH];
  logic [1:0]              rev_o  [MAX_WIDTH];
  logic [1:0]              tv_o   [MAX_WIDTH];
  logic signed [SUM_W-1:0] accf_o [MAX_WIDTH];
  logic signed [SUM_W-1:0] accr_o [MAX_WIDTH];

  function automatic logic signed [SW-1:0] sat_score(input logic signed [SUM_W-1:0] s);
    logic signed [SW-1:0] r;
    if (s > SUM_MAX) begin
      r = pwsc_pkg::SCORE_MAX;
    end else if (s < SUM_MIN) begin
      r = pwsc_pkg::SCORE_MIN;
    end else begin
      r = s[SW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- cell chain
  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    logic [1:0]              win_i, rev_i, tv_i;
    logic signed [SUM_W-1:0] accf_i, accr_i;
    logic                    sel;

    if (k == 0) begin : g_first
      assign win_i = in_base;
    end else begin : g_mid
      assign win_i = win_o[k-1];
    end

    // top cell takes the new base into the reversed window and zero sums
    if (k == MAX_WIDTH - 1) begin : g_top
      assign rev_i  = in_base;
      assign tv_i   = 2'b00;
      assign accf_i = '0;
      assign accr_i = '0;
    end else begin : g_low
      assign rev_i  = rev_o[k+1];
      assign tv_i   = tv_o[k+1];
      assign accf_i = accf_o[k+1];
      assign accr_i = accr_o[k+1];
    end

    assign sel = wr_en && (32'(in_column) == k);

    pwsc_cell #(
      .SUM_W(SUM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .wr_sel   (sel),
      .win_in   (win_i),
      .rev_in   (rev_i),
      .tv_in    (tv_i),
      .accf_in  (accf_i),
      .accr_in  (accr_i),
      .win_out  (win_o[k]),
      .rev_out  (rev_o[k]),
      .tv_out   (tv_o[k]),
      .accf_out (accf_o[k]),
      .accr_out (accr_o[k])
    );
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    if (motif_width_r == 6'd0) begin
      used_w = UW_W'(1);
    end else if (32'(motif_width_r) > MAX_WIDTH) begin
      used_w = UW_W'(MAX_WIDTH);
    end else begin
      used_w = UW_W'(motif_width_r);
    end
  end

  assign shift_len = UW_W'(MAX_WIDTH) - used_w;
  assign fill_inc  = (fill_r == UW_W'(MAX_WIDTH)) ? fill_r : fill_r + UW_W'(1);
  assign in_tready = (state_r == pwsc_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign emit_load = (state_r == pwsc_pkg::ST_EMIT) && (!out_valid_r || out_tready);
  assign seq_clear = emit_load && is_base_r && last_r;

  assign fs_ext   = (SW+1)'(fs_r);
  assign rs_ext   = (SW+1)'(rs_r);
  assign best_bar = (SW+1)'(best_val_r) + (SW+1)'(pwsc_pkg::TIE_MARGIN);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    count_nxt      = count_r;
    wstart_nxt     = wstart_r;
    last_nxt       = last_r;
    is_base_nxt    = is_base_r;
    wvalid_nxt     = wvalid_r;
    fs_nxt         = fs_r;
    rs_nxt         = rs_r;
    best_val_nxt   = best_val_r;
    best_pos_nxt   = best_pos_r;
    best_rev_nxt   = best_rev_r;
    best_found_nxt = best_found_r;
    wr_en          = 1'b0;

    ctrl            = '0;
    ctrl.wr_row     = in_base;
    ctrl.wr_data    = in_weight;

    case (state_r)
      pwsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          last_nxt   = in_tlast;
          wvalid_nxt = 1'b0;
          cnt_nxt    = '0;
          if (in_tuser == pwsc_pkg::FUNC_WEIGHT) begin
            is_base_nxt = 1'b0;
            wr_en       = 1'b1;
            state_nxt   = pwsc_pkg::ST_EMIT;
          end else begin
            is_base_nxt     = 1'b1;
            ctrl.shift_base = 1'b1;
            fill_nxt        = fill_inc;
            count_nxt       = count_r + POS_BITS'(1);
            wstart_nxt      = count_r - POS_BITS'(used_w - UW_W'(1));
            if (fill_inc >= used_w) begin
              wvalid_nxt = 1'b1;
              if (shift_len == '0) begin
                ctrl.clr_acc = 1'b1;
                state_nxt    = pwsc_pkg::ST_SUM;
              end else begin
                state_nxt = pwsc_pkg::ST_SHIFT;
              end
            end else begin
              state_nxt = pwsc_pkg::ST_EMIT;
            end
          end
        end
      end
      // line the reversed window up so cell i holds the base for column i
      pwsc_pkg::ST_SHIFT: begin
        ctrl.shift_tv = 1'b1;
        cnt_nxt       = cnt_r + UW_W'(1);
        if (cnt_r == shift_len - UW_W'(1)) begin
          ctrl.clr_acc = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = pwsc_pkg::ST_SUM;
        end
      end
      // sums drop one cell per cycle toward cell 0
      pwsc_pkg::ST_SUM: begin
        ctrl.run_acc = 1'b1;
        cnt_nxt      = cnt_r + UW_W'(1);
        if (cnt_r == used_w - UW_W'(1)) begin
          state_nxt = pwsc_pkg::ST_SCORE;
        end
      end
      pwsc_pkg::ST_SCORE: begin
        fs_nxt    = sat_score(accf_o[0]);
        rs_nxt    = sat_score(accr_o[0]);
        state_nxt = pwsc_pkg::ST_BEST_F;
      end
      pwsc_pkg::ST_BEST_F: begin
        if (!best_found_r || (fs_ext >= best_bar)) begin
          best_val_nxt   = fs_r;
          best_pos_nxt   = wstart_r;
          best_rev_nxt   = 1'b0;
          best_found_nxt = 1'b1;
        end
        state_nxt = pwsc_pkg::ST_BEST_R;
      end
      pwsc_pkg::ST_BEST_R: begin
        if (!best_found_r || (rs_ext >= best_bar)) begin
          best_val_nxt   = rs_r;
          best_pos_nxt   = wstart_r;
          best_rev_nxt   = 1'b1;
          best_found_nxt = 1'b1;
        end
        state_nxt = pwsc_pkg::ST_EMIT;
      end
      pwsc_pkg::ST_EMIT: begin
        if (emit_load) begin
          state_nxt = pwsc_pkg::ST_IDLE;
          if (seq_clear) begin
            ctrl.clr_scan  = 1'b1;
            fill_nxt       = '0;
            count_nxt      = '0;
            best_val_nxt   = pwsc_pkg::SCORE_MIN;
            best_pos_nxt   = '0;
            best_rev_nxt   = 1'b0;
            best_found_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = pwsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pwsc_pkg::ST_IDLE;
      cnt_r        <= '0;
      fill_r       <= '0;
      count_r      <= '0;
      is_base_r    <= 1'b0;
      last_r       <= 1'b0;
      wvalid_r     <= 1'b0;
      best_val_r   <= pwsc_pkg::SCORE_MIN;
      best_pos_r   <= '0;
      best_rev_r   <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_r       <= fill_nxt;
      count_r      <= count_nxt;
      is_base_r    <= is_base_nxt;
      last_r       <= last_nxt;
      wvalid_r     <= wvalid_nxt;
      best_val_r   <= best_val_nxt;
      best_pos_r   <= best_pos_nxt;
      best_rev_r   <= best_rev_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wstart_r <= wstart_nxt;
    fs_r     <= fs_nxt;
    rs_r     <= rs_nxt;
  end

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motif_width_r <= 6'd1;
      hit_thr_r     <= pwsc_pkg::SCORE_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwsc_pkg::REG_MOTIF_WIDTH:   motif_width_r <= cfg_data[5:0];
        pwsc_pkg::REG_HIT_THRESHOLD: hit_thr_r     <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  assign wstart_ext = {{PW{1'b0}}, wstart_r};
  assign bstart_ext = {{PW{1'b0}}, best_pos_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_wvalid_r <= wvalid_r;
      out_done_r   <= is_base_r && last_r;
      out_best_r   <= best_val_r;
      out_bstart_r <= bstart_ext[PW-1:0];
      out_brev_r   <= best_rev_r;
      if (wvalid_r) begin
        out_wstart_r <= wstart_ext[PW-1:0];
        out_fs_r     <= fs_r;
        out_rs_r     <= rs_r;
        out_fh_r     <= fs_r > hit_thr_r;
        out_rh_r     <= rs_r > hit_thr_r;
      end else begin
        out_wstart_r <= '0;
        out_fs_r     <= '0;
        out_rs_r     <= '0;
        out_fh_r     <= 1'b0;
        out_rh_r     <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_wvalid_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {1'b0, out_brev_r, out_bstart_r, out_best_r, out_rh_r, out_fh_r,
                       out_rs_r, out_fs_r, out_wstart_r};

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != pwsc_pkg::ST_IDLE)
    else $error("controller idle after an input transfer");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= UW_W'(MAX_WIDTH))
    else $error("window fill beyond chain length");

  a_nowin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[57:0] == '0)
    else $error("window fields set without a window");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    seq_clear |=> fill_r == '0 && count_r == '0 && !best_found_r)
    else $error("scan state kept after sequence end");
`endif

endmodule

// File: dv/tb_pwm_window_scorer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pwm_window_scorer
// Self-checking bench for the log-domain motif scanner. Loads the weight
// matrix, streams DNA base sequences under several widths and thresholds,
// and checks every result against a local score and best-window tracker.
// Directed cases cover tie handling, score saturation and back-pressure.
// A random part then runs under three sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_pwm_window_scorer;

  localparam int MAX_W = 32;

  typedef logic signed [pwsc_pkg::WEIGHT_W-1:0] weight_t;
  typedef logic signed [pwsc_pkg::SCORE_W-1:0]  score_t;

  typedef struct packed {
    logic        win_valid;
    logic [15:0] win_start;
    score_t      fwd;
    score_t      rev;
    logic        fhit;
    logic        rhit;
    score_t      best;
    logic [15:0] best_start;
    logic        best_rev;
    logic        done;
  } window_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [23:0]  in_tdata;   // base[1:0], column[6:2], weight[22:7], zero
  logic         in_tuser;   // func
  logic         in_tlast;   // last_base
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // window_start, fwd_score, rev_score,
                            // forward_hit, reverse_hit, peak_score,
                            // best_start, best_reverse, zero
  logic         out_tuser;  // window_valid
  logic         out_tlast;  // sequence_done
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [19:0]  cfg_data;

  // scanner mirror
  weight_t     wgt_mem [0:3][0:MAX_W-1];
  logic [1:0]  base_hist [0:MAX_W-1];
  logic [15:0] seq_pos;
  int          hist_fill;
  score_t      top_score;
  logic [15:0] top_start;
  logic        top_on_rev;
  logic        top_valid;
  logic [5:0]  cur_width;
  score_t      cur_threshold;

  window_result_t pending_scores [$];
  int mismatch_count;
  int results_seen;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_req;
  int hold_left;

  pwm_window_scorer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- mirror

  function automatic int eff_width();
    if (cur_width == 6'd0) return 1;
    if (cur_width > MAX_W) return MAX_W;
    return int'(cur_width);
  endfunction

  function automatic score_t clamp_score(input int s);
    if (s < int'(pwsc_pkg::SCORE_MIN)) return pwsc_pkg::SCORE_MIN;
    if (s > int'(pwsc_pkg::SCORE_MAX)) return pwsc_pkg::SCORE_MAX;
    return score_t'(s);
  endfunction

  function automatic void clear_scan();
    int i;
    for (i = 0; i < MAX_W; i++) base_hist[i] = 2'd0;
    seq_pos    = 16'd0;
    hist_fill  = 0;
    top_score  = pwsc_pkg::SCORE_MIN;
    top_start  = 16'd0;
    top_on_rev = 1'b0;
    top_valid  = 1'b0;
  endfunction

  // a later window only wins when it beats the best by the tie margin
  function automatic void update_best(input score_t sc,
                                      input logic [15:0] st, input logic on_rev);
    if (!top_valid || int'(sc) >= int'(top_score) + pwsc_pkg::TIE_MARGIN) begin
      top_score  = sc;
      top_start  = st;
      top_on_rev = on_rev;
      top_valid  = 1'b1;
    end
  endfunction

  function automatic window_result_t predict_result(input logic func,
      input logic [1:0] b, input logic [4:0] col,
      input weight_t wt, input logic last);
    window_result_t r;
    int w, fsum, rsum, i;
    logic [1:0] nb;
    r = '0;
    if (func == pwsc_pkg::FUNC_WEIGHT) begin
      wgt_mem[b][col] = wt;
    end else begin
      w = eff_width();
      for (i = MAX_W - 1; i > 0; i--) base_hist[i] = base_hist[i-1];
      base_hist[0] = b;
      if (hist_fill < MAX_W) hist_fill++;
      if (hist_fill >= w) begin
        fsum = 0;
        rsum = 0;
        for (i = 0; i < w; i++) begin
          nb = base_hist[w-1-i];
          fsum += wgt_mem[nb][i];
          rsum += wgt_mem[2'd3 - nb][w-1-i];
        end
        r.win_valid = 1'b1;
        r.win_start = seq_pos - 16'(w - 1);
        r.fwd       = clamp_score(fsum);
        r.rev       = clamp_score(rsum);
        r.fhit      = r.fwd > cur_threshold;
        r.rhit      = r.rev > cur_threshold;
        update_best(r.fwd, r.win_start, 1'b0);
        update_best(r.rev, r.win_start, 1'b1);
      end
      seq_pos++;
      r.done = last;
    end
    r.best       = top_score;
    r.best_start = top_start;
    r.best_rev   = top_on_rev;
    if (r.done) clear_scan();
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending",
                                  results_seen));
      end else begin
        want = pending_scores.pop_front();
        check_field("window_valid", out_tuser, want.win_valid);
        check_field("window_start", out_tdata[15:0], want.win_start);
        check_field("fwd_score", $signed(out_tdata[35:16]), want.fwd);
        check_field("rev_score", $signed(out_tdata[55:36]), want.rev);
        check_field("forward_hit", out_tdata[56], want.fhit);
        check_field("reverse_hit", out_tdata[57], want.rhit);
        check_field("peak_score", $signed(out_tdata[77:58]), want.best);
        check_field("best_start", out_tdata[93:78], want.best_start);
        check_field("best_reverse", out_tdata[94], want.best_rev);
        check_field("sequence_done", out_tlast, want.done);
      end
      results_seen++;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic func, input logic [1:0] b,
                           input logic [4:0] col,
                           input weight_t wt, input logic last);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, wt, col, b};
    in_tuser  <= func;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    pending_scores.push_back(predict_result(func, b, col, wt, last));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
  endtask

  // both registers in one burst, only once the scanner is idle
  task automatic set_config(input logic [5:0] width, input score_t thr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= pwsc_pkg::REG_MOTIF_WIDTH;
    cfg_data  <= {14'd0, width};
    do @(posedge clk); while (!cfg_ready);
    cur_width = width;
    cfg_index <= pwsc_pkg::REG_HIT_THRESHOLD;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cur_threshold = thr;
    cfg_valid <= 1'b0;
  endtask

  // flavor 1 keeps weights tiny so near ties are common
  function automatic weight_t rand_weight(input int flavor);
    if (flavor == 1) return weight_t'(-int'($urandom_range(0, 3)));
    case ($urandom_range(3))
      0:       return weight_t'(-int'($urandom_range(0, 32768)));
      1:       return weight_t'(-int'($urandom_range(0, 3)));
      2:       return weight_t'($urandom);
      default: return weight_t'(-int'($urandom_range(900, 1100)));
    endcase
  endfunction

  function automatic score_t rand_threshold();
    return score_t'(-int'($urandom_range(0, 524288)));
  endfunction

  task automatic load_table(input int flavor);
    int r, c;
    for (r = 0; r < 4; r++)
      for (c = 0; c < MAX_W; c++)
        send_item(pwsc_pkg::FUNC_WEIGHT, 2'(r), 5'(c), rand_weight(flavor),
                  1'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // whole matrix first, so no unwritten weight is ever read
  task automatic test_load_table();
    load_table(0);
  endtask

  // width 0 acts as 1; equal and one-off scores keep the earlier best, one at the tie margin takes over
  task automatic test_tie_break();
    set_config(6'd0, -20'sd99);
    send_item(pwsc_pkg::FUNC_WEIGHT, 2'd0, 5'd0, -16'sd100, 1'b1);
    send_item(pwsc_pkg::FUNC_WEIGHT, 2'd1, 5'd0, -16'sd99, 1'b0);
    send_item(pwsc_pkg::FUNC_WEIGHT, 2'd2, 5'd0, -16'sd98, 1'b0);
    send_item(pwsc_pkg::FUNC_WEIGHT, 2'd3, 5'd0, -16'sd100, 1'b0);
    send_item(pwsc_pkg::FUNC_BASE, 2'd0, 5'd31, 16'sd0, 1'b0);
    send_item(pwsc_pkg::FUNC_BASE, 2'd1, 5'd0, -16'sd1, 1'b0);
    send_item(pwsc_pkg::FUNC_BASE, 2'd2, 5'd31, 16'sd0, 1'b0);
    send_item(pwsc_pkg::FUNC_BASE, 2'd3, 5'd0, -16'sd1, 1'b1);
  endtask

  // width above the limit acts as the full matrix; sums clamp both ways
  task automatic test_saturation();
    int c;
    set_config(6'd63, pwsc_pkg::SCORE_MAX);
    for (c = 0; c < MAX_W; c++) begin
      send_item(pwsc_pkg::FUNC_WEIGHT, 2'd0, 5'(c), 16'sd32767, 1'b0);
      send_item(pwsc_pkg::FUNC_WEIGHT, 2'd3, 5'(c), -16'sd32768, 1'b0);
    end
    for (c = 0; c <= MAX_W; c++)
      send_item(pwsc_pkg::FUNC_BASE, 2'd0, 5'(c), 16'sd0, c == MAX_W);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int k;
    set_config(6'd4, -20'sd40000);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 400;
    for (k = 0; k < 30; k++)
      send_item(pwsc_pkg::FUNC_BASE, 2'($urandom), 5'($urandom), rand_weight(0),
                k == 29);
    wait_drained();
  endtask

  task automatic test_random(input int n_items, input int flavor, input bit reload);
    int sent, seq_len, k;
    if (reload) load_table(flavor);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_item(pwsc_pkg::FUNC_WEIGHT, 2'($urandom), 5'($urandom),
                  rand_weight(flavor), 1'($urandom));
        sent++;
      end else begin
        seq_len = $urandom_range(1, eff_width() + 40);
        for (k = 0; k < seq_len; k++) begin
          // a few sequences run on without a closing base
          send_item(pwsc_pkg::FUNC_BASE, 2'($urandom), 5'($urandom),
                    rand_weight(flavor), k == seq_len - 1 && $urandom_range(9) != 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= pwsc_pkg::FUNC_WEIGHT;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= pwsc_pkg::REG_MOTIF_WIDTH;
    cfg_data   <= '0;
    mismatch_count = 0;
    results_seen   = 0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    hold_req       = 0;
    hold_left      = 0;
    cur_width      = 6'd1;
    cur_threshold  = pwsc_pkg::SCORE_MIN;
    clear_scan();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 29;
    sink_idle_pct = 86;
    test_load_table();
    test_tie_break();
    test_saturation();
    test_backpressure();

    src_idle_pct  = 29;
    sink_idle_pct = 86;
    set_config(6'd32, pwsc_pkg::SCORE_MIN);
    test_random(160, 0, 1'b0);
    set_config(6'd1, 20'sd0);
    test_random(160, 1, 1'b1);

    src_idle_pct  = 86;
    sink_idle_pct = 29;
    set_config(6'd63, rand_threshold());
    test_random(160, 0, 1'b1);
    set_config(6'd0, pwsc_pkg::SCORE_MAX);
    test_random(160, 0, 1'b0);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_config(6'($urandom_range(1, 32)), rand_threshold());
    test_random(160, 1, 1'b1);
    set_config(6'($urandom_range(1, 32)), rand_threshold());
    test_random(160, 0, 1'b1);

    wait_drained();
    repeat (MAX_W + 10) @(posedge clk);
    if (pending_scores.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_scores.size()));
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
